### rtl/core/base64_stream_codec_assert.svh
// ---------------------------------------------------------------------------
// base64_stream_codec_assert
// Assertion macros for the base64 stream codec.
// ---------------------------------------------------------------------------
// Every property is sampled on clk and disabled while rst_n is low.
`ifndef BASE64_STREAM_CODEC_ASSERT_SVH
`define BASE64_STREAM_CODEC_ASSERT_SVH

// Condition holds in the same cycle.
`define B64SC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("base64 codec check failed");

// Condition holds in the next cycle.
`define B64SC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("base64 codec check failed");

`endif

### rtl/core/b64sc_pkg.sv
// ---------------------------------------------------------------------------
// b64sc_pkg
// Types, constants and alphabet functions for the base64 stream codec.
// ---------------------------------------------------------------------------
package b64sc_pkg;

    localparam int GROUP_W   = 18;  // gathered bytes or 6-bit indices
    localparam int MAX_WORDS = 4;   // most words one item can give
    localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } in_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       error;
    } out_t;

    // 6-bit index to alphabet character
    function automatic logic [7:0] char_of(input logic [5:0] idx);
        logic [7:0] c;
        if (idx < 6'd26)
            c = 8'h41 + {2'b00, idx};
        else if (idx < 6'd52)
            c = 8'h61 + {2'b00, idx - 6'd26};
        else if (idx < 6'd62)
            c = 8'h30 + {2'b00, idx - 6'd52};
        else if (idx == 6'd62)
            c = 8'h2B;
        else
            c = 8'h2F;
        return c;
    endfunction

    // alphabet character to 6-bit index; anything else gives 0
    function automatic logic [5:0] index_of(input logic [7:0] c);
        logic [5:0] idx;
        if (c inside {[8'h41:8'h5A]})
            idx = 6'(c - 8'h41);
        else if (c inside {[8'h61:8'h7A]})
            idx = 6'(c - 8'h61 + 8'd26);
        else if (c inside {[8'h30:8'h39]})
            idx = 6'(c - 8'h30 + 8'd52);
        else if (c == 8'h2B)
            idx = 6'd62;
        else if (c == 8'h2F)
            idx = 6'd63;
        else
            idx = 6'd0;
        return idx;
    endfunction

endpackage

### rtl/core/base64_stream_codec.sv
// ---------------------------------------------------------------------------
// base64_stream_codec
// Streaming base64 encoder/decoder, standard alphabet, mode-selected.
// ---------------------------------------------------------------------------
// Usage:
//  - item channel (item, item_valid, item_stall): one byte (encode) or one
//    character (decode) per word, item.last marks the end of a message.
//  - result channel (result, result_valid, result_stall): 0 to 4 words per
//    item; result.last flags the final word caused by an item, result.error
//    flags a decode message that ended inside a group.
//  - cfg channel (cfg_mode, cfg_valid, cfg_ready): writes the mode bit
//    (0 encode, 1 decode) and drops any partial group. cfg_ready is high
//    only while the block is drained.
//  - Path: an accepted item is held in the input register, is
//    processed into the result buffer once that frees up, and its first
//    word then shows from the buffer.
//  - Throughput: one item per cycle while items give no words; an item
//    that gives words holds the result buffer until all are sent, and
//    the item behind it waits in the input register meanwhile.
//  - Reset clears the mode (encode), the group state and all valid flags.
//  - A stalled receiver freezes the buffered word; once the buffer is full
//    and the input register occupied, item_stall rises.
// ---------------------------------------------------------------------------
`include "base64_stream_codec_assert.svh"

module base64_stream_codec (
    input  logic            clk,
    input  logic            rst_n,
    input  b64sc_pkg::in_t  item,
    input  logic            item_valid,
    output logic            item_stall,
    output b64sc_pkg::out_t result,
    output logic            result_valid,
    input  logic            result_stall,
    input  logic            cfg_mode,
    input  logic            cfg_valid,
    output logic            cfg_ready
);

    // input register
    b64sc_pkg::in_t in_reg;
    logic           in_full_reg, in_full_next;

    // group state
    logic                          mode_reg, mode_next;
    logic [b64sc_pkg::GROUP_W-1:0] bits_reg, bits_next;
    logic [1:0]                    cnt_reg, cnt_next;
    logic [1:0]                    pad_reg, pad_next;

    // result buffer
    b64sc_pkg::out_t wbuf_reg [b64sc_pkg::MAX_WORDS];
    b64sc_pkg::out_t words    [b64sc_pkg::MAX_WORDS];
    logic [2:0]      rem_reg, rem_next;   // words still to send
    logic [1:0]      ptr_reg, ptr_next;   // next word to send
    logic [2:0]      wcnt;                // words made by the item in hand

    logic       take, move, cfg_wr, accept;
    logic [1:0] n_enc;
    logic [5:0] idx;
    logic [23:0] v;

    assign take   = result_valid && !result_stall;
    // input item moves into the buffer as it frees up this cycle
    assign move   = in_full_reg && ((rem_reg == 3'd0) || ((rem_reg == 3'd1) && take));
    assign accept = item_valid && !item_stall;
    assign cfg_wr = cfg_valid && cfg_ready;

    assign item_stall   = in_full_reg && !move;
    assign result_valid = (rem_reg != 3'd0);
    assign result       = wbuf_reg[ptr_reg];
    assign cfg_ready    = !in_full_reg && (rem_reg == 3'd0);

    // word generation and group update for the item in the input register, or group clear on a cfg write
    always_comb
    begin
        for (int i = 0; i < b64sc_pkg::MAX_WORDS; i++)
        begin
            words[i] = '0;
        end
        wcnt      = '0;
        mode_next = mode_reg;
        bits_next = bits_reg;
        cnt_next  = cnt_reg;
        pad_next  = pad_reg;
        n_enc     = cnt_reg + 2'd1;
        idx       = b64sc_pkg::index_of(in_reg.value);
        v         = '0;

        if (cfg_wr)
        begin
            mode_next = cfg_mode;
            bits_next = '0;
            cnt_next  = '0;
            pad_next  = '0;
        end
        else if (move)
        begin
            if (mode_reg == b64sc_pkg::MODE_ENCODE)
            begin
                // held count of 3 only arises in decode, treat as full group
                if ((cnt_reg < 2'd2) && !in_reg.last)
                begin
                    bits_next = {bits_reg[9:0], in_reg.value};
                    cnt_next  = n_enc;
                end
                else
                begin
                    if (cnt_reg >= 2'd2)
                        v = {bits_reg[15:0], in_reg.value};
                    else if (cnt_reg == 2'd1)
                        v = {bits_reg[7:0], in_reg.value, 8'h00};
                    else
                        v = {in_reg.value, 16'h0000};
                    words[0].value = b64sc_pkg::char_of(v[23:18]);
                    words[1].value = b64sc_pkg::char_of(v[17:12]);
                    words[2].value = (cnt_reg >= 2'd1) ? b64sc_pkg::char_of(v[11:6])
                                                       : b64sc_pkg::PAD_CHAR;
                    words[3].value = (cnt_reg >= 2'd2) ? b64sc_pkg::char_of(v[5:0])
                                                       : b64sc_pkg::PAD_CHAR;
                    wcnt      = 3'd4;
                    bits_next = '0;
                    cnt_next  = '0;
                    pad_next  = '0;
                end
            end
            else
            begin
                if (cnt_reg < 2'd3)
                begin
                    bits_next = {bits_reg[11:0], idx};
                    if ((cnt_reg == 2'd2) && (in_reg.value == b64sc_pkg::PAD_CHAR))
                        pad_next = pad_reg | 2'b01;
                    cnt_next = cnt_reg + 2'd1;
                    if (in_reg.last)
                    begin
                        // short message: single error word, group dropped
                        words[0].error = 1'b1;
                        wcnt      = 3'd1;
                        bits_next = '0;
                        cnt_next  = '0;
                        pad_next  = '0;
                    end
                end
                else
                begin
                    v = {bits_reg, idx};
                    words[wcnt[1:0]].value = v[23:16];
                    wcnt = wcnt + 3'd1;
                    if (!pad_reg[0])
                    begin
                        words[wcnt[1:0]].value = v[15:8];
                        wcnt = wcnt + 3'd1;
                    end
                    if (in_reg.value != b64sc_pkg::PAD_CHAR)
                    begin
                        words[wcnt[1:0]].value = v[7:0];
                        wcnt = wcnt + 3'd1;
                    end
                    bits_next = '0;
                    cnt_next  = '0;
                    pad_next  = '0;
                end
            end
            if (wcnt != 3'd0)
                words[2'(wcnt - 3'd1)].last = 1'b1;
        end
    end

    // buffer and input register control
    always_comb
    begin
        in_full_next = in_full_reg;
        rem_next     = rem_reg;
        ptr_next     = ptr_reg;
        if (move)
        begin
            rem_next     = wcnt;
            ptr_next     = '0;
            in_full_next = 1'b0;
        end
        else if (take)
        begin
            rem_next = rem_reg - 3'd1;
            ptr_next = ptr_reg + 2'd1;
        end
        if (accept)
            in_full_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            mode_reg    <= b64sc_pkg::MODE_ENCODE;
            bits_reg    <= '0;
            cnt_reg     <= '0;
            pad_reg     <= '0;
            rem_reg     <= '0;
            ptr_reg     <= '0;
        end
        else
        begin
            in_full_reg <= in_full_next;
            mode_reg    <= mode_next;
            bits_reg    <= bits_next;
            cnt_reg     <= cnt_next;
            pad_reg     <= pad_next;
            rem_reg     <= rem_next;
            ptr_reg     <= ptr_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            in_reg <= item;
        if (move)
        begin
            for (int i = 0; i < b64sc_pkg::MAX_WORDS; i++)
            begin
                wbuf_reg[i] <= words[i];
            end
        end
    end

    // checks
    `B64SC_ASSERT_NOW(a_cfg_only_drained, cfg_ready, !result_valid && !in_full_reg)
    `B64SC_ASSERT_NEXT(a_cfg_clears_group, cfg_valid && cfg_ready, cnt_reg == 2'd0)
    `B64SC_ASSERT_NEXT(a_accept_fills_input, item_valid && !item_stall, in_full_reg)
    `B64SC_ASSERT_NOW(a_error_is_last, result_valid && result.error, result.last)

endmodule
